[design/pcfc_pkg.sv]
// ----------------------------------------------------------------------------
// pcfc_pkg
// Shared types, constants and color helpers for the pixel format converter.
// ----------------------------------------------------------------------------
package pcfc_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int IDX_W       = 8;
  localparam int PIX_W       = 24;
  localparam int CONV_W      = 4;
  localparam int PROD_W      = 20;

  localparam logic [11:0] GREY_R_K = 12'd871;
  localparam logic [11:0] GREY_G_K = 12'd2929;
  localparam logic [11:0] GREY_B_K = 12'd295;

  localparam logic [15:0] MASK_R565 = 16'hf800;
  localparam logic [15:0] MASK_G565 = 16'h07e0;
  localparam logic [15:0] MASK_B565 = 16'h001f;
  localparam logic [7:0]  MASK_5B   = 8'hf8;
  localparam logic [7:0]  MASK_6B   = 8'hfc;

  localparam logic REG_CONV = 1'b0;

  typedef enum logic [CONV_W-1:0] {
    CONV_IDX_888  = 4'd0,
    CONV_IDX_565  = 4'd1,
    CONV_565_888  = 4'd2,
    CONV_888_565  = 4'd3,
    CONV_888_GREY = 4'd4,
    CONV_565_GREY = 4'd5,
    CONV_IDX_GREY = 4'd6,
    CONV_SWAP24   = 4'd7,
    CONV_SWAP565  = 4'd8
  } conv_t;

  typedef struct packed {
    logic                    valid;
    logic [CONV_W-1:0]       conv;
    logic [PIX_W-1:0]        word;
    logic                    idx_ok;
  } pcfc_item_t;

  function automatic logic [15:0] to565(input logic [PIX_W-1:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    to565 = {r[7:3] & MASK_5B[7:3], g[7:2] & MASK_6B[7:2], b[7:3]};
  endfunction

  function automatic logic [PIX_W-1:0] to888(input logic [15:0] c);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    r = c & MASK_R565;
    g = c & MASK_G565;
    b = c & MASK_B565;
    to888 = {r[15:11], 3'b000, g[10:5], 2'b00, b[4:0], 3'b000};
  endfunction

  function automatic logic [15:0] swap565(input logic [15:0] c);
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    r = c & MASK_R565;
    g = c & MASK_G565;
    b = c & MASK_B565;
    swap565 = {b[4:0], g[10:5], r[15:11]};
  endfunction

endpackage

[design/pixel_color_format_converter.sv]
// ----------------------------------------------------------------------------
// pixel_color_format_converter
// Palette-based pixel format converter (index, RGB888, RGB565, grey).
//
//   port group   direction  transfer
//   in_*         in         start high and busy low at a rising edge
//   out_*        out        out_valid high for one cycle
//   p* (APB)     in/out     psel, penable, pwrite high (pready tied high)
//
// One item per cycle; busy stays low. A pixel result passes through the
// palette RAM read, color select and grey products, then sum and output
// register. Palette writes give no result.
// Synchronous active-low reset clears the pipeline and the conversion
// register; palette contents are undefined until written.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module pixel_color_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [7:0]  in_palette_index,
  input  logic [23:0] in_pixel_word,
  output logic        out_valid,
  output logic [23:0] out_pixel_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcfc_pkg::*;

  logic              accept;
  logic              idx_ok;
  logic [CONV_W-1:0] conversion;
  logic [PIX_W-1:0]  pal_rdata;
  pcfc_item_t        item_r;
  pcfc_item_t        item_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign idx_ok = {1'b0, in_palette_index} < (IDX_W + 1)'(PAL_ENTRIES);

  pcfc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .conversion (conversion)
  );

  pcfc_palette_ram #(
    .DEPTH (PAL_ENTRIES),
    .WIDTH (PIX_W),
    .AW    (PAL_AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept & ~in_mode & idx_ok),
    .addr  (in_palette_index[PAL_AW-1:0]),
    .wdata (in_pixel_word),
    .rdata (pal_rdata)
  );

  always_comb begin
    item_nxt.valid  = accept & in_mode;
    item_nxt.conv   = conversion;
    item_nxt.word   = in_pixel_word;
    item_nxt.idx_ok = idx_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_nxt.valid;
    end
    item_r.conv   <= item_nxt.conv;
    item_r.word   <= item_nxt.word;
    item_r.idx_ok <= item_nxt.idx_ok;
  end

  pcfc_convert u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_r),
    .pal_rdata (pal_rdata),
    .res_valid (out_valid),
    .res_pixel (out_pixel_out)
  );

`ifndef SYNTHESIS
  a_pixel_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |-> ##3 out_valid)
    else $error("pixel transfer without result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy && in_mode) |-> ##3 !out_valid)
    else $error("result without pixel transfer");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[2] == REG_CONV) |=>
      (paddr[2] != REG_CONV || prdata[CONV_W-1:0] == $past(pwdata[CONV_W-1:0])))
    else $error("conversion register write lost");

  a_grey_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (item_r.valid && (item_r.conv == CONV_888_GREY || item_r.conv == CONV_565_GREY ||
      item_r.conv == CONV_IDX_GREY)) |-> ##2 (out_pixel_out[23:8] == 16'h0000))
    else $error("grey result has upper bits set");
`endif

endmodule

[design/pcfc_palette_ram.sv]
// ----------------------------------------------------------------------------
// pcfc_palette_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module pcfc_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/pcfc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcfc_cfg_regs
// APB register file: holds the conversion select.
// ----------------------------------------------------------------------------
module pcfc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [pcfc_pkg::CONV_W-1:0] conversion
);
  import pcfc_pkg::*;

  logic [CONV_W-1:0] conv_r;
  logic [CONV_W-1:0] conv_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_CONV);

  always_comb begin
    conv_nxt = conv_r;
    if (wr_en) begin
      conv_nxt = pwdata[CONV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= CONV_IDX_888;
    end else begin
      conv_r <= conv_nxt;
    end
  end

  assign prdata     = (paddr[2] == REG_CONV) ? {{(32-CONV_W){1'b0}}, conv_r} : 32'd0;
  assign conversion = conv_r;

endmodule

[design/pcfc_convert.sv]
// ----------------------------------------------------------------------------
// pcfc_convert
// Two-stage conversion datapath: color select and grey products, then sum
// and output register.
// ----------------------------------------------------------------------------
module pcfc_convert (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcfc_pkg::pcfc_item_t       item,
  input  logic [pcfc_pkg::PIX_W-1:0] pal_rdata,
  output logic                       res_valid,
  output logic [pcfc_pkg::PIX_W-1:0] res_pixel
);
  import pcfc_pkg::*;

  logic [PIX_W-1:0]  pal;
  logic [PIX_W-1:0]  src;
  logic [PIX_W-1:0]  direct;
  logic              grey;
  logic [15:0]       w16;

  logic              v2_r;
  logic              grey_r;
  logic [PIX_W-1:0]  direct_r;
  logic [PROD_W-1:0] pr_r;
  logic [PROD_W-1:0] pg_r;
  logic [PROD_W-1:0] pb_r;

  logic [PROD_W-1:0] sum;
  logic              v3_r;
  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  pix_nxt;

  assign pal = item.idx_ok ? pal_rdata : '0;
  assign w16 = item.word[15:0];

  always_comb begin
    src    = item.word;
    direct = '0;
    grey   = 1'b0;
    case (conv_t'(item.conv))
      CONV_IDX_888:  direct = pal;
      CONV_IDX_565:  direct = {8'h00, to565(pal)};
      CONV_565_888:  direct = to888(w16);
      CONV_888_565:  direct = {8'h00, to565(item.word)};
      CONV_888_GREY: grey   = 1'b1;
      CONV_565_GREY: begin
        grey = 1'b1;
        src  = to888(w16);
      end
      CONV_IDX_GREY: begin
        grey = 1'b1;
        src  = pal;
      end
      CONV_SWAP24:   direct = {item.word[7:0], item.word[15:8], item.word[23:16]};
      CONV_SWAP565:  direct = {8'h00, swap565(w16)};
      default:       direct = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= item.valid;
    end
    grey_r   <= grey;
    direct_r <= direct;
    pr_r     <= PROD_W'(src[23:16]) * PROD_W'(GREY_R_K);
    pg_r     <= PROD_W'(src[15:8]) * PROD_W'(GREY_G_K);
    pb_r     <= PROD_W'(src[7:0]) * PROD_W'(GREY_B_K);
  end

  assign sum     = pr_r + pg_r + pb_r;
  assign pix_nxt = grey_r ? {16'h0000, sum[PROD_W-1:12]} : direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    pix_r <= pix_nxt;
  end

  assign res_valid = v3_r;
  assign res_pixel = pix_r;

endmodule
